FILE: hdl/gyro_rate_to_delta_quaternion_macros.svh
// Assertion macros for the delta quaternion block
`ifndef GYRO_RATE_TO_DELTA_QUATERNION_MACROS_SVH
`define GYRO_RATE_TO_DELTA_QUATERNION_MACROS_SVH

// same-cycle implication
`define GRQ_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("grq: implication check failed");

// next-cycle implication
`define GRQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("grq: next-cycle check failed");

`endif

FILE: hdl/grq_pkg.sv
package grq_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd16777;

	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [34:0] TWO_PI_Q30 = 35'sd6746518852;
	localparam logic signed [33:0] GAIN_INV_Q30 = 34'sd652032874;

	function automatic logic [31:0] atan_q30(input int idx);
		logic [31:0] v;
		case (idx)
			0: v = 32'h3243F6A8;
			1: v = 32'h1DAC6705;
			2: v = 32'h0FADBAFC;
			3: v = 32'h07F56EA6;
			4: v = 32'h03FEAB76;
			5: v = 32'h01FFD55B;
			6: v = 32'h00FFFAAA;
			7: v = 32'h007FFF55;
			8: v = 32'h003FFFEA;
			9: v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			24: v = 32'h0000003F;
			25: v = 32'h0000001F;
			26: v = 32'h0000000F;
			27: v = 32'h00000008;
			28: v = 32'h00000004;
			29: v = 32'h00000002;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

FILE: hdl/grq_sqrt_cell.sv
module grq_sqrt_cell #(
	parameter int IDX = 0,
	parameter int TW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input logic [63:0] in_v,
	input logic [63:0] in_r,
	input logic [TW-1:0] in_tag,
	output logic out_vld,
	output logic [63:0] out_v,
	output logic [63:0] out_r,
	output logic [TW-1:0] out_tag
);

	localparam logic [63:0] BITV = 64'd1 << (62 - 2 * IDX);

	logic [63:0] trial;
	logic [63:0] v_n, r_n;
	logic vld_q;
	logic [63:0] v_q, r_q;
	logic [TW-1:0] tag_q;

	always_comb begin
		trial = in_r + BITV;
		if (in_v >= trial) begin
			v_n = in_v - trial;
			r_n = (in_r >> 1) + BITV;
		end else begin
			v_n = in_v;
			r_n = in_r >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_q <= v_n;
			r_q <= r_n;
			tag_q <= in_tag;
		end
	end

	assign out_vld = vld_q;
	assign out_v = v_q;
	assign out_r = r_q;
	assign out_tag = tag_q;

endmodule

FILE: hdl/grq_div_cell.sv
module grq_div_cell #(
	parameter int RW = 32,
	parameter int NW = 31,
	parameter int LANES = 1,
	parameter int TW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input logic [RW-1:0] in_d,
	input logic [LANES-1:0][RW-1:0] in_rem,
	input logic [LANES-1:0][NW-1:0] in_num,
	input logic [LANES-1:0][NW-1:0] in_quo,
	input logic [TW-1:0] in_tag,
	output logic out_vld,
	output logic [RW-1:0] out_d,
	output logic [LANES-1:0][RW-1:0] out_rem,
	output logic [LANES-1:0][NW-1:0] out_num,
	output logic [LANES-1:0][NW-1:0] out_quo,
	output logic [TW-1:0] out_tag
);

	logic [LANES-1:0][RW-1:0] rem_n;
	logic [LANES-1:0][NW-1:0] num_n, quo_n;
	logic vld_q;
	logic [RW-1:0] d_q;
	logic [LANES-1:0][RW-1:0] rem_q;
	logic [LANES-1:0][NW-1:0] num_q, quo_q;
	logic [TW-1:0] tag_q;

	always_comb begin
		logic [RW:0] t;
		logic ge;
		for (int l = 0; l < LANES; l++) begin
			t = {in_rem[l], in_num[l][NW-1]};
			ge = t >= {1'b0, in_d};
			rem_n[l] = ge ? RW'(t - {1'b0, in_d}) : t[RW-1:0];
			num_n[l] = {in_num[l][NW-2:0], 1'b0};
			quo_n[l] = {in_quo[l][NW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= in_d;
			rem_q <= rem_n;
			num_q <= num_n;
			quo_q <= quo_n;
			tag_q <= in_tag;
		end
	end

	assign out_vld = vld_q;
	assign out_d = d_q;
	assign out_rem = rem_q;
	assign out_num = num_q;
	assign out_quo = quo_q;
	assign out_tag = tag_q;

endmodule

FILE: hdl/grq_cordic_cell.sv
module grq_cordic_cell #(
	parameter int IDX = 0,
	parameter int TW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input logic signed [33:0] in_x,
	input logic signed [33:0] in_y,
	input logic signed [33:0] in_z,
	input logic [TW-1:0] in_tag,
	output logic out_vld,
	output logic signed [33:0] out_x,
	output logic signed [33:0] out_y,
	output logic signed [33:0] out_z,
	output logic [TW-1:0] out_tag
);

	localparam logic signed [33:0] ANG = signed'({2'b00, grq_pkg::atan_q30(IDX)});

	logic signed [33:0] xs, ys;
	logic signed [33:0] x_n, y_n, z_n;
	logic vld_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [TW-1:0] tag_q;

	always_comb begin
		xs = in_x >>> IDX;
		ys = in_y >>> IDX;
		if (in_z >= 0) begin
			x_n = in_x - ys;
			y_n = in_y + xs;
			z_n = in_z - ANG;
		end else begin
			x_n = in_x + ys;
			y_n = in_y - xs;
			z_n = in_z + ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			tag_q <= in_tag;
		end
	end

	assign out_vld = vld_q;
	assign out_x = x_q;
	assign out_y = y_q;
	assign out_z = z_q;
	assign out_tag = tag_q;

endmodule

FILE: hdl/gyro_rate_to_delta_quaternion.sv
// Channel   | Signals                                  | Direction | Handshake
// ----------+------------------------------------------+-----------+--------------
// in        | rate_x/y/z, bias_x/y/z                   | input     | in_valid/in_ready
// out       | quat_w/x/y/z, zero_rotation              | output    | out_valid/out_ready
// cfg       | cfg_wr_data (sample_period)              | input     | cfg_wr_en
//
// One request enters per cycle while in_ready is high; the path to out_valid runs through
// the two 32-cell square-root chains, the two 31-cell divider chains, the 14-cell modulo
// chain and the CORDIC chain.
// arst_n clears all valid bits and loads the default period.
// All stages advance together; a stalled output register holds the whole pipe.
`include "gyro_rate_to_delta_quaternion_macros.svh"

module gyro_rate_to_delta_quaternion #(
	parameter int CORDIC_STEPS = grq_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [23:0] cfg_wr_data,
	input logic in_valid,
	output logic in_ready,
	input logic signed [31:0] rate_x,
	input logic signed [31:0] rate_y,
	input logic signed [31:0] rate_z,
	input logic signed [31:0] bias_x,
	input logic signed [31:0] bias_y,
	input logic signed [31:0] bias_z,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z,
	output logic zero_rotation
);

	typedef struct packed {
		logic [2:0][30:0] b;
		logic [4:0] k;
		logic [2:0] neg;
		logic zero;
	} sq1_tag_t;

	typedef struct packed {
		logic [45:0] h;
		logic [2:0] neg;
		logic zero;
	} div1_tag_t;

	typedef struct packed {
		logic [2:0][31:0] u;
		logic zero;
	} mod_tag_t;

	typedef struct packed {
		logic [2:0][31:0] u;
		logic flip;
		logic zero;
	} cor_tag_t;

	typedef struct packed {
		logic [3:0][31:0] mag;
		logic [3:0] neg;
		logic zero;
	} sq2_tag_t;

	typedef struct packed {
		logic [3:0] neg;
		logic zero;
		logic nz;
	} div2_tag_t;

	localparam int SQ1_TW = $bits(sq1_tag_t);
	localparam int DIV1_TW = $bits(div1_tag_t);
	localparam int MOD_TW = $bits(mod_tag_t);
	localparam int COR_TW = $bits(cor_tag_t);
	localparam int SQ2_TW = $bits(sq2_tag_t);
	localparam int DIV2_TW = $bits(div2_tag_t);

	logic adv;
	logic [23:0] sample_period_q;

	logic out_valid_q;
	logic signed [31:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	logic zero_rotation_q;

	// front end
	logic signed [31:0] rate_a [3];
	logic signed [31:0] bias_a [3];
	logic [32:0] ext_c [3];
	logic signed [31:0] sat_c [3];
	logic signed [24:0] period_sx;
	logic [54:0] m_c;
	logic [4:0] k_c;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [31:0] sum_s1 [3];
	logic signed [55:0] p_s2 [3];
	logic [54:0] a_s3 [3];
	logic [2:0] neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [54:0] a_s4 [3];
	logic [4:0] k_s4, k_s5, k_s6, k_s7;
	logic zero_s4, zero_s5, zero_s6, zero_s7, zero_s8;
	logic [2:0][30:0] b_s5, b_s6, b_s7, b_s8;
	logic [61:0] bsq_s6 [3];
	logic [63:0] ss_s7;

	logic sq1_vld [0:32];
	logic [63:0] sq1_v [0:32];
	logic [63:0] sq1_r [0:32];
	logic [SQ1_TW-1:0] sq1_tag [0:32];
	sq1_tag_t sq1_in, sq1_out;
	logic [31:0] len_c;
	logic [31:0] len_s8;
	logic [45:0] h_s8;

	logic d1_vld [0:31];
	logic [31:0] d1_d [0:31];
	logic [2:0][31:0] d1_rem [0:31];
	logic [2:0][30:0] d1_num [0:31];
	logic [2:0][30:0] d1_quo [0:31];
	logic [DIV1_TW-1:0] d1_tag [0:31];
	div1_tag_t d1_in, d1_out;

	logic md_vld [0:14];
	logic [32:0] md_d [0:14];
	logic [0:0][32:0] md_rem [0:14];
	logic [0:0][13:0] md_num [0:14];
	logic [0:0][13:0] md_quo [0:14];
	logic [MOD_TW-1:0] md_tag [0:14];
	mod_tag_t md_in, md_out;

	logic signed [34:0] zr_c;
	logic flip_c;
	logic vld_s10;
	logic signed [33:0] z_s10;
	logic flip_s10, zero_s10;
	logic [2:0][31:0] u_s10;

	logic cr_vld [0:CORDIC_STEPS];
	logic signed [33:0] cr_x [0:CORDIC_STEPS];
	logic signed [33:0] cr_y [0:CORDIC_STEPS];
	logic signed [33:0] cr_z [0:CORDIC_STEPS];
	logic [COR_TW-1:0] cr_tag [0:CORDIC_STEPS];
	cor_tag_t cr_in, cr_out;

	logic vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16;
	logic signed [33:0] x_s11, y_s11;
	logic [2:0][31:0] u_s11;
	logic zero_s11, zero_s12, zero_s13, zero_s14, zero_s15, zero_s16;
	logic signed [63:0] prod_s12 [3];
	logic signed [31:0] x_s12;
	logic signed [31:0] q_s13 [4];
	logic [31:0] mag_c [4];
	logic [3:0][31:0] mag_s14, mag_s15;
	logic [3:0] neg_s14, neg_s15, neg_s16;
	logic [63:0] qsq_s14 [4];
	logic [63:0] n2_s15;

	logic sq2_vld [0:32];
	logic [63:0] sq2_v [0:32];
	logic [63:0] sq2_r [0:32];
	logic [SQ2_TW-1:0] sq2_tag [0:32];
	sq2_tag_t sq2_in, sq2_out;
	logic [31:0] norm_c;
	logic [31:0] dn_s16;
	logic [3:0][31:0] magc_s16;
	logic nz_s16;

	logic d2_vld [0:31];
	logic [31:0] d2_d [0:31];
	logic [3:0][31:0] d2_rem [0:31];
	logic [3:0][30:0] d2_num [0:31];
	logic [3:0][30:0] d2_quo [0:31];
	logic [DIV2_TW-1:0] d2_tag [0:31];
	div2_tag_t d2_in, d2_out;
	logic signed [31:0] res_c [4];

	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= grq_pkg::SAMPLE_PERIOD_RST;
		end else if (cfg_wr_en) begin
			sample_period_q <= cfg_wr_data;
		end
	end

	// valid chain of the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= sq1_vld[32];
			vld_s10 <= md_vld[14];
			vld_s11 <= cr_vld[CORDIC_STEPS];
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= sq2_vld[32];
			out_valid_q <= d2_vld[31];
		end
	end

	// saturating bias add, scale by period, magnitude and normalize
	assign rate_a[0] = rate_x;
	assign rate_a[1] = rate_y;
	assign rate_a[2] = rate_z;
	assign bias_a[0] = bias_x;
	assign bias_a[1] = bias_y;
	assign bias_a[2] = bias_z;
	assign period_sx = signed'({1'b0, sample_period_q});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ext_c[i] = {rate_a[i][31], rate_a[i]} + {bias_a[i][31], bias_a[i]};
			if (ext_c[i][32] != ext_c[i][31]) begin
				sat_c[i] = ext_c[i][32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
			end else begin
				sat_c[i] = signed'(ext_c[i][31:0]);
			end
		end
	end

	always_comb begin
		m_c = a_s3[0] | a_s3[1] | a_s3[2];
		k_c = '0;
		for (int j = 31; j < 55; j++) begin
			if (m_c[j]) begin
				k_c = 5'(j - 30);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sum_s1[i] <= sat_c[i];
				p_s2[i] <= sum_s1[i] * period_sx;
				a_s3[i] <= p_s2[i][55] ? 55'(-p_s2[i]) : 55'(p_s2[i]);
				neg_s3[i] <= p_s2[i][55];
				a_s4[i] <= a_s3[i];
				b_s5[i] <= 31'(a_s4[i] >> k_s4);
				bsq_s6[i] <= b_s5[i] * b_s5[i];
			end
			neg_s4 <= neg_s3;
			k_s4 <= k_c;
			zero_s4 <= m_c == '0;
			neg_s5 <= neg_s4;
			k_s5 <= k_s4;
			zero_s5 <= zero_s4;
			b_s6 <= b_s5;
			neg_s6 <= neg_s5;
			k_s6 <= k_s5;
			zero_s6 <= zero_s5;
			ss_s7 <= 64'(bsq_s6[0]) + 64'(bsq_s6[1]) + 64'(bsq_s6[2]);
			b_s7 <= b_s6;
			neg_s7 <= neg_s6;
			k_s7 <= k_s6;
			zero_s7 <= zero_s6;
		end
	end

	// square root of the squared length
	always_comb begin
		sq1_in.b = b_s7;
		sq1_in.k = k_s7;
		sq1_in.neg = neg_s7;
		sq1_in.zero = zero_s7;
	end

	assign sq1_vld[0] = vld_s7;
	assign sq1_v[0] = ss_s7;
	assign sq1_r[0] = '0;
	assign sq1_tag[0] = sq1_in;

	for (genvar g = 0; g < 32; g++) begin : g_sq1
		grq_sqrt_cell #(.IDX(g), .TW(SQ1_TW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_vld(sq1_vld[g]), .in_v(sq1_v[g]), .in_r(sq1_r[g]), .in_tag(sq1_tag[g]),
			.out_vld(sq1_vld[g+1]), .out_v(sq1_v[g+1]), .out_r(sq1_r[g+1]),
			.out_tag(sq1_tag[g+1])
		);
	end

	assign sq1_out = sq1_tag[32];
	assign len_c = (sq1_r[32][31:0] == '0) ? 32'd1 : sq1_r[32][31:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s8 <= len_c;
			h_s8 <= 46'(({25'b0, len_c} << sq1_out.k) >> 11);
			b_s8 <= sq1_out.b;
			neg_s8 <= sq1_out.neg;
			zero_s8 <= sq1_out.zero;
		end
	end

	// unit axis: (b << 30) / len
	always_comb begin
		d1_in.h = h_s8;
		d1_in.neg = neg_s8;
		d1_in.zero = zero_s8;
		for (int i = 0; i < 3; i++) begin
			d1_rem[0][i] = {2'b00, b_s8[i][30:1]};
			d1_num[0][i] = {b_s8[i][0], 30'b0};
			d1_quo[0][i] = '0;
		end
	end

	assign d1_vld[0] = vld_s8;
	assign d1_d[0] = len_s8;
	assign d1_tag[0] = d1_in;

	for (genvar g = 0; g < 31; g++) begin : g_div1
		grq_div_cell #(.RW(32), .NW(31), .LANES(3), .TW(DIV1_TW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_vld(d1_vld[g]), .in_d(d1_d[g]), .in_rem(d1_rem[g]), .in_num(d1_num[g]),
			.in_quo(d1_quo[g]), .in_tag(d1_tag[g]),
			.out_vld(d1_vld[g+1]), .out_d(d1_d[g+1]), .out_rem(d1_rem[g+1]),
			.out_num(d1_num[g+1]), .out_quo(d1_quo[g+1]), .out_tag(d1_tag[g+1])
		);
	end

	assign d1_out = d1_tag[31];

	// half angle modulo two pi
	always_comb begin
		md_in.zero = d1_out.zero;
		for (int i = 0; i < 3; i++) begin
			md_in.u[i] = d1_out.neg[i] ? 32'(-{1'b0, d1_quo[31][i]}) : {1'b0, d1_quo[31][i]};
		end
	end

	assign md_vld[0] = d1_vld[31];
	assign md_d[0] = 33'(grq_pkg::TWO_PI_Q30);
	assign md_rem[0][0] = {1'b0, d1_out.h[45:14]};
	assign md_num[0][0] = d1_out.h[13:0];
	assign md_quo[0][0] = '0;
	assign md_tag[0] = md_in;

	for (genvar g = 0; g < 14; g++) begin : g_mod
		grq_div_cell #(.RW(33), .NW(14), .LANES(1), .TW(MOD_TW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_vld(md_vld[g]), .in_d(md_d[g]), .in_rem(md_rem[g]), .in_num(md_num[g]),
			.in_quo(md_quo[g]), .in_tag(md_tag[g]),
			.out_vld(md_vld[g+1]), .out_d(md_d[g+1]), .out_rem(md_rem[g+1]),
			.out_num(md_num[g+1]), .out_quo(md_quo[g+1]), .out_tag(md_tag[g+1])
		);
	end

	assign md_out = md_tag[14];

	// fold into [-pi/2, pi/2]
	always_comb begin
		zr_c = signed'({2'b00, md_rem[14][0]});
		flip_c = 1'b0;
		if (zr_c > grq_pkg::PI_Q30) begin
			zr_c = zr_c - grq_pkg::TWO_PI_Q30;
		end
		if (zr_c > grq_pkg::HALF_PI_Q30) begin
			zr_c = zr_c - grq_pkg::PI_Q30;
			flip_c = 1'b1;
		end else if (zr_c < -grq_pkg::HALF_PI_Q30) begin
			zr_c = zr_c + grq_pkg::PI_Q30;
			flip_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s10 <= 34'(zr_c);
			flip_s10 <= flip_c;
			u_s10 <= md_out.u;
			zero_s10 <= md_out.zero;
		end
	end

	// rotation-mode CORDIC
	always_comb begin
		cr_in.u = u_s10;
		cr_in.flip = flip_s10;
		cr_in.zero = zero_s10;
	end

	assign cr_vld[0] = vld_s10;
	assign cr_x[0] = grq_pkg::GAIN_INV_Q30;
	assign cr_y[0] = '0;
	assign cr_z[0] = z_s10;
	assign cr_tag[0] = cr_in;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cor
		grq_cordic_cell #(.IDX(g), .TW(COR_TW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_vld(cr_vld[g]), .in_x(cr_x[g]), .in_y(cr_y[g]), .in_z(cr_z[g]),
			.in_tag(cr_tag[g]),
			.out_vld(cr_vld[g+1]), .out_x(cr_x[g+1]), .out_y(cr_y[g+1]), .out_z(cr_z[g+1]),
			.out_tag(cr_tag[g+1])
		);
	end

	assign cr_out = cr_tag[CORDIC_STEPS];

	// quaternion components and squared norm
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag_c[i] = q_s13[i][31] ? 32'(-q_s13[i]) : q_s13[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s11 <= cr_out.flip ? -cr_x[CORDIC_STEPS] : cr_x[CORDIC_STEPS];
			y_s11 <= cr_out.flip ? -cr_y[CORDIC_STEPS] : cr_y[CORDIC_STEPS];
			u_s11 <= cr_out.u;
			zero_s11 <= cr_out.zero;
			for (int i = 0; i < 3; i++) begin
				prod_s12[i] <= signed'(u_s11[i]) * signed'(y_s11[31:0]);
				q_s13[i+1] <= 32'(prod_s12[i] >>> 30);
			end
			x_s12 <= x_s11[31:0];
			zero_s12 <= zero_s11;
			q_s13[0] <= x_s12;
			zero_s13 <= zero_s12;
			for (int i = 0; i < 4; i++) begin
				mag_s14[i] <= mag_c[i];
				neg_s14[i] <= q_s13[i][31];
				qsq_s14[i] <= mag_c[i] * mag_c[i];
			end
			zero_s14 <= zero_s13;
			n2_s15 <= qsq_s14[0] + qsq_s14[1] + qsq_s14[2] + qsq_s14[3];
			mag_s15 <= mag_s14;
			neg_s15 <= neg_s14;
			zero_s15 <= zero_s14;
		end
	end

	always_comb begin
		sq2_in.mag = mag_s15;
		sq2_in.neg = neg_s15;
		sq2_in.zero = zero_s15;
	end

	assign sq2_vld[0] = vld_s15;
	assign sq2_v[0] = n2_s15;
	assign sq2_r[0] = '0;
	assign sq2_tag[0] = sq2_in;

	for (genvar g = 0; g < 32; g++) begin : g_sq2
		grq_sqrt_cell #(.IDX(g), .TW(SQ2_TW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_vld(sq2_vld[g]), .in_v(sq2_v[g]), .in_r(sq2_r[g]), .in_tag(sq2_tag[g]),
			.out_vld(sq2_vld[g+1]), .out_v(sq2_v[g+1]), .out_r(sq2_r[g+1]),
			.out_tag(sq2_tag[g+1])
		);
	end

	assign sq2_out = sq2_tag[32];
	assign norm_c = sq2_r[32][31:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			nz_s16 <= norm_c == '0;
			dn_s16 <= (norm_c == '0) ? 32'd1 : norm_c;
			for (int i = 0; i < 4; i++) begin
				magc_s16[i] <= (sq2_out.mag[i] > norm_c) ? norm_c : sq2_out.mag[i];
			end
			neg_s16 <= sq2_out.neg;
			zero_s16 <= sq2_out.zero;
		end
	end

	// renormalize: (|c| << 30) / norm
	always_comb begin
		d2_in.neg = neg_s16;
		d2_in.zero = zero_s16;
		d2_in.nz = nz_s16;
		for (int i = 0; i < 4; i++) begin
			d2_rem[0][i] = {1'b0, magc_s16[i][31:1]};
			d2_num[0][i] = {magc_s16[i][0], 30'b0};
			d2_quo[0][i] = '0;
		end
	end

	assign d2_vld[0] = vld_s16;
	assign d2_d[0] = dn_s16;
	assign d2_tag[0] = d2_in;

	for (genvar g = 0; g < 31; g++) begin : g_div2
		grq_div_cell #(.RW(32), .NW(31), .LANES(4), .TW(DIV2_TW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_vld(d2_vld[g]), .in_d(d2_d[g]), .in_rem(d2_rem[g]), .in_num(d2_num[g]),
			.in_quo(d2_quo[g]), .in_tag(d2_tag[g]),
			.out_vld(d2_vld[g+1]), .out_d(d2_d[g+1]), .out_rem(d2_rem[g+1]),
			.out_num(d2_num[g+1]), .out_quo(d2_quo[g+1]), .out_tag(d2_tag[g+1])
		);
	end

	assign d2_out = d2_tag[31];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			res_c[i] = d2_out.neg[i] ? 32'(-{1'b0, d2_quo[31][i]}) : {1'b0, d2_quo[31][i]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (d2_out.zero || d2_out.nz) begin
				quat_w_q <= grq_pkg::ONE_Q30;
				quat_x_q <= '0;
				quat_y_q <= '0;
				quat_z_q <= '0;
			end else begin
				quat_w_q <= res_c[0];
				quat_x_q <= res_c[1];
				quat_y_q <= res_c[2];
				quat_z_q <= res_c[3];
			end
			zero_rotation_q <= d2_out.zero;
		end
	end

	assign out_valid = out_valid_q;
	assign quat_w = quat_w_q;
	assign quat_x = quat_x_q;
	assign quat_y = quat_y_q;
	assign quat_z = quat_z_q;
	assign zero_rotation = zero_rotation_q;

	`GRQ_ASSERT_IMPLY(a_zero_identity, clk, arst_n, out_valid && zero_rotation, quat_w == grq_pkg::ONE_Q30 && quat_x == '0 && quat_y == '0 && quat_z == '0)
	`GRQ_ASSERT_IMPLY(a_w_range, clk, arst_n, out_valid, quat_w <= grq_pkg::ONE_Q30 && quat_w >= -grq_pkg::ONE_Q30)
	`GRQ_ASSERT_NEXT(a_stall_hold, clk, arst_n, !in_ready, $stable(vld_s1) && $stable(vld_s16))

endmodule
